// File: src/assert_macros.svh
// Assertion macros shared by the RTL of the actuator controller.
// No dependencies; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

// File: src/udac_pkg.sv
// Package for the up/down actuator controller: phase, action, function and
// register codes, reset values and divide-by-100 constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package udac_pkg;

    localparam int TIME_BITS = 32;

    // phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_UP   = 2'd1;
    localparam logic [1:0] PH_DOWN = 2'd2;
    localparam logic [1:0] PH_COOL = 2'd3;

    // action codes
    localparam logic [1:0] ACT_STOP = 2'd0;
    localparam logic [1:0] ACT_UP   = 2'd1;
    localparam logic [1:0] ACT_DOWN = 2'd2;
    localparam logic [1:0] ACT_BAD  = 2'd3;

    // input function codes
    localparam logic FUNC_TICK    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_STANDARD = 2'd0;
    localparam logic [1:0] CFG_MAX      = 2'd1;
    localparam logic [1:0] CFG_COOL     = 2'd2;

    // reset values
    localparam logic [31:0] STANDARD_RESET = 32'd100000;
    localparam logic [31:0] MAX_RESET      = 32'd100000;
    localparam logic [31:0] COOL_RESET     = 32'd50000;
    localparam logic [31:0] LIMIT_RESET    = 32'd100000;

    // percent scaling: floor(x / 100) == (x * 5243) >> 19 for x < 43699
    localparam int          PCT_FULL    = 100;
    localparam logic [6:0]  PCT_CLAMP   = 7'd100;
    localparam logic [19:0] RECIP_100   = 20'd5243;
    localparam int          RECIP_SHIFT = 19;

    // floor(x / 100) == (x * RECIP_100_WIDE) >> RECIP_WIDE_SHIFT for any 32-bit x
    localparam logic [31:0] RECIP_100_WIDE   = 32'h51EB_851F;
    localparam int          RECIP_WIDE_SHIFT = 37;

    // standard time split into quotient and scaled remainder of /100
    localparam int QUO_BITS = 26;
    localparam int RK_BITS  = 20;
    localparam logic [QUO_BITS-1:0] QUO_RESET = QUO_BITS'(STANDARD_RESET / PCT_FULL);
    localparam logic [RK_BITS-1:0]  RK_RESET  =
        RK_BITS'((STANDARD_RESET % PCT_FULL) * 5243);

    // split sequencer: quotient cycle, then remainder cycle
    localparam int DIV_STEPS = 2;
    localparam int CNT_BITS  = 1;

endpackage

`default_nettype wire

// File: src/up_down_actuator_controller.sv
// Top level of the up/down actuator controller: request store, tick phase
// machine, result register and the split by 100 for timed mode.
// Depends on udac_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// The input register takes the item at the transfer; the result register takes
// it through the single phase-machine update when it is empty or being drained.
// Throughput: one item per cycle while neither out_stall nor a split holds it.
// A write to standard_moving_ms holds cfg_ready and raises in_stall while a
// reciprocal multiply splits the value by 100.
// Reset (rst_n low, asynchronous) empties both stages, sets phase idle, action
// stop, manual mode, limit 100000, phase start 0 and the register defaults.
module up_down_actuator_controller
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        func,
    input  wire logic [1:0]  action,
    input  wire logic        timed_mode,
    input  wire logic [9:0]  duration_percent,
    input  wire logic [udac_pkg::TIME_BITS-1:0] now_ms,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             drive_up,
    output logic             drive_down,
    output logic [1:0]       phase,
    output logic             notify,
    output logic [1:0]       notify_kind,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import udac_pkg::*;

    `include "assert_macros.svh"

    // ------------------------------------------------------------------
    // Configuration registers and the split of standard_moving_ms by 100.
    // ------------------------------------------------------------------
    logic [31:0]          max_reg;
    logic [31:0]          cool_reg;
    logic [QUO_BITS-1:0]  quo_reg;      // standard_moving_ms / 100
    logic [RK_BITS-1:0]   rk_reg;       // (standard_moving_ms % 100) * 5243
    logic                 busy_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [31:0]          dv_reg;       // standard_moving_ms being split
    logic [QUO_BITS-1:0]  dq_reg;       // its quotient, held for the remainder

    logic [63:0]          recip_prod;
    logic [QUO_BITS-1:0]  dq_next;
    logic [31:0]          dq_times;
    logic [6:0]           rem_next;
    logic [RK_BITS-1:0]   rk_next;
    logic                 cfg_fire;
    logic                 div_last;

    assign cfg_ready = !busy_reg;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign div_last  = busy_reg && (cnt_reg == CNT_BITS'(DIV_STEPS - 1));

    always_comb
    begin
        // first step: quotient by reciprocal multiplication
        recip_prod = 64'(dv_reg) * 64'(RECIP_100_WIDE);
        dq_next    = recip_prod[RECIP_WIDE_SHIFT+QUO_BITS-1:RECIP_WIDE_SHIFT];
        // second step: remainder and its scaled form
        dq_times   = 32'(dq_reg) * 32'(PCT_FULL);
        rem_next   = 7'(dv_reg - dq_times);
        rk_next    = RK_BITS'(RK_BITS'(rem_next) * RECIP_100);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg  <= MAX_RESET;
            cool_reg <= COOL_RESET;
            quo_reg  <= QUO_RESET;
            rk_reg   <= RK_RESET;
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_fire)
            begin
                case (cfg_index)
                    CFG_STANDARD:
                    begin
                        busy_reg <= 1'b1;
                        cnt_reg  <= '0;
                    end
                    CFG_MAX:  max_reg  <= cfg_data;
                    CFG_COOL: cool_reg <= cfg_data;
                    default:  ;     // index beyond the list: drop the write
                endcase
            end
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (div_last)
                begin
                    busy_reg <= 1'b0;
                    quo_reg  <= dq_reg;
                    rk_reg   <= rk_next;
                end
            end
        end
    end

    // datapath of the split needs no reset
    always_ff @(posedge clk)
    begin
        if (cfg_fire && cfg_index == CFG_STANDARD)
            dv_reg <= cfg_data;
        if (busy_reg && cnt_reg == '0)
            dq_reg <= dq_next;
    end

    // ------------------------------------------------------------------
    // Pipeline control: input register, then result register.
    // ------------------------------------------------------------------
    logic        s1_valid_reg;
    logic        out_valid_reg;
    logic        out_load;
    logic        s1_load;

    // result register takes a new item when empty or being drained
    assign out_load  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign s1_load   = in_valid && !in_stall;
    // hold the input while splitting or while both stages are full and blocked
    assign in_stall  = busy_reg || (s1_valid_reg && !out_load);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= 1'b1;
            else if (out_load)
                s1_valid_reg <= 1'b0;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // input register payload
    logic                 s1_func_reg;
    logic [1:0]           s1_action_reg;
    logic                 s1_timed_reg;
    logic [9:0]           s1_pct_reg;
    logic [TIME_BITS-1:0] s1_now_reg;

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_func_reg   <= func;
            s1_action_reg <= action;
            s1_timed_reg  <= timed_mode;
            s1_pct_reg    <= duration_percent;
            s1_now_reg    <= now_ms;
        end
    end

    // ------------------------------------------------------------------
    // Controller state and the step logic.
    // ------------------------------------------------------------------
    logic [1:0]           phase_reg;
    logic [1:0]           wanted_reg;
    logic                 mode_reg;
    logic [31:0]          limit_reg;
    logic [TIME_BITS-1:0] start_reg;

    logic [1:0]           phase_next;
    logic [1:0]           wanted_next;
    logic                 mode_next;
    logic [31:0]          limit_next;
    logic [TIME_BITS-1:0] start_next;
    logic                 entered;

    logic [6:0]           pct_clamped;
    logic [32:0]          prod_quo;
    logic [26:0]          prod_rem;
    logic [31:0]          limit_timed;
    logic [TIME_BITS-1:0] elapsed;
    logic [1:0]           act_match;
    logic [1:0]           act_opp;

    always_comb
    begin
        // timed limit: quo*p + floor(rem*p/100), exact since quo*p is whole
        pct_clamped = (s1_pct_reg > 10'(PCT_CLAMP)) ? PCT_CLAMP : s1_pct_reg[6:0];
        prod_quo    = 33'(quo_reg) * 33'(pct_clamped);
        prod_rem    = 27'(rk_reg) * 27'(pct_clamped);
        limit_timed = prod_quo[31:0] + 32'(prod_rem[RECIP_SHIFT+6:RECIP_SHIFT]);

        elapsed   = s1_now_reg - start_reg;
        act_match = (phase_reg == PH_UP) ? ACT_UP : ACT_DOWN;
        act_opp   = (phase_reg == PH_UP) ? ACT_DOWN : ACT_UP;

        phase_next  = phase_reg;
        wanted_next = wanted_reg;
        mode_next   = mode_reg;
        limit_next  = limit_reg;
        start_next  = start_reg;
        entered     = 1'b0;

        if (s1_func_reg == FUNC_REQUEST)
        begin
            wanted_next = (s1_action_reg == ACT_BAD) ? ACT_STOP : s1_action_reg;
            mode_next   = s1_timed_reg;
            limit_next  = s1_timed_reg ? limit_timed : max_reg;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (wanted_reg != ACT_STOP)
                    begin
                        phase_next = (wanted_reg == ACT_UP) ? PH_UP : PH_DOWN;
                        start_next = s1_now_reg;
                        entered    = 1'b1;
                    end
                end
                PH_UP, PH_DOWN:
                begin
                    if (!(wanted_reg == act_match && 64'(elapsed) < 64'(limit_reg)))
                    begin
                        // reverse on the opposite request, else cool down
                        phase_next = (wanted_reg == act_opp) ? act_opp : PH_COOL;
                        start_next = s1_now_reg;
                        entered    = 1'b1;
                    end
                end
                PH_COOL:
                begin
                    wanted_next = ACT_STOP;
                    if (64'(elapsed) >= 64'(cool_reg))
                        phase_next = PH_IDLE;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            wanted_reg <= ACT_STOP;
            mode_reg   <= 1'b0;
            limit_reg  <= LIMIT_RESET;
            start_reg  <= '0;
        end
        else if (out_load)
        begin
            phase_reg  <= phase_next;
            wanted_reg <= wanted_next;
            mode_reg   <= mode_next;
            limit_reg  <= limit_next;
            start_reg  <= start_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    logic       drive_up_reg;
    logic       drive_down_reg;
    logic [1:0] phase_out_reg;
    logic       notify_reg;
    logic [1:0] kind_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            drive_up_reg   <= (phase_next == PH_UP);
            drive_down_reg <= (phase_next == PH_DOWN);
            phase_out_reg  <= phase_next;
            notify_reg     <= entered && mode_next;
            // kind follows the new phase: up 0, down 1, cool down (stop) 2
            kind_reg       <= (entered && mode_next) ? 2'(phase_next - 2'd1) : 2'd0;
        end
    end

    assign drive_up    = drive_up_reg;
    assign drive_down  = drive_down_reg;
    assign phase       = phase_out_reg;
    assign notify      = notify_reg;
    assign notify_kind = kind_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `ASSERT_NEVER(a_both_drives, clk, rst_n, out_valid_reg && drive_up_reg && drive_down_reg)
    `ASSERT_CLK(a_notify_not_idle, clk, rst_n,
        (out_valid_reg && notify_reg) |-> (phase_out_reg != PH_IDLE))
    `ASSERT_CLK(a_no_transfer_dividing, clk, rst_n, busy_reg |-> (in_stall && !cfg_ready))
    `ASSERT_CLK(a_divide_starts, clk, rst_n,
        (cfg_fire && cfg_index == CFG_STANDARD) |=> (busy_reg && cnt_reg == '0))

endmodule

`default_nettype wire
